@@ src/fsg_pkg.sv @@
package fsg_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam logic [31:0] F32_ZERO    = 32'h0000_0000;
  localparam logic [31:0] F32_POS_INF = 32'h7F80_0000;
  localparam logic [31:0] F32_NEG_INF = 32'hFF80_0000;
  localparam logic [63:0] F64_ZERO    = 64'h0;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    GUARD_OFF      = 2'd0,
    GUARD_SANITIZE = 2'd1,
    GUARD_STRICT   = 2'd2
  } guard_e;

  typedef enum logic [1:0] {
    FAIL_NONFINITE = 2'd0,
    FAIL_BOUNDS    = 2'd1,
    FAIL_BOTH      = 2'd2
  } fail_e;

  typedef enum logic [7:0] {
    REG_MODE_SEL        = 8'd0,
    REG_NONFIN_CHK      = 8'd1,
    REG_BOUND_CHK       = 8'd2,
    REG_BOUND_ENABLES   = 8'd3,
    REG_MIN_BOUND       = 8'd4,
    REG_MAX_BOUND       = 8'd5,
    REG_FAIL_CRITERION  = 8'd6,
    REG_STRICT_IN_SCOPE = 8'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  mode_sel;
    logic        nonfin_chk;
    logic        bound_chk;
    logic [1:0]  bound_enables;
    logic [31:0] min_bound;
    logic [31:0] max_bound;
    logic [1:0]  fail_criterion;
    logic        strict_in_scope;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_bits;
    logic        end_mark;
    logic [31:0] nan_total;
    logic [31:0] inf_total;
    logic [31:0] finite_total;
    logic [31:0] below_total;
    logic [31:0] above_total;
    logic [31:0] least_bits;
    logic [31:0] greatest_bits;
    logic [63:0] sum_bits;
    logic [3:0]  violation_flags;
    logic        strict_failed;
  } out_item_t;

  // Per-sample classification handed from the sample unit to the statistics.
  typedef struct packed {
    logic is_nan;
    logic is_inf;
    logic is_fin;
    logic below;
    logic above;
  } cls_t;

  function automatic logic f32_is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // IEEE less-than: false on NaN, zeros of either sign compare equal.
  function automatic logic f32_lt(logic [31:0] a, logic [31:0] b);
    logic res;
    if (f32_is_nan(a) || f32_is_nan(b)) begin
      res = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

  function automatic count_t cnt_bump(count_t c, logic en);
    return (en && (c != '1)) ? c + count_t'(1) : c;
  endfunction

  function automatic logic [31:0] cnt_show(count_t c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

@@ src/fsg_sample.sv @@
module fsg_sample (
  input  logic [31:0]   sample_i,
  input  fsg_pkg::cfg_t cfg_i,
  output logic [31:0]   out_bits_o,
  output fsg_pkg::cls_t cls_o
);
  import fsg_pkg::*;

  logic        has_lo, has_hi, bd_en, sanitize, nonfin;
  logic        lt_lo, gt_hi;
  logic [31:0] hi_or_zero, repl, clamp_v;

  assign has_lo   = cfg_i.bound_enables[0];
  assign has_hi   = cfg_i.bound_enables[1];
  assign bd_en    = cfg_i.bound_chk && (cfg_i.bound_enables != 2'd0);
  assign sanitize = (cfg_i.mode_sel == GUARD_SANITIZE);
  assign nonfin   = (sample_i[30:23] == 8'hFF);

  // min(hi, 0) and max(lo, that), NaN bounds pass through
  assign hi_or_zero = f32_lt(F32_ZERO, cfg_i.max_bound) ? F32_ZERO : cfg_i.max_bound;

  always_comb begin
    if (has_lo && has_hi) begin
      repl = f32_lt(cfg_i.min_bound, hi_or_zero) ? hi_or_zero : cfg_i.min_bound;
    end else if (has_lo) begin
      repl = cfg_i.min_bound;
    end else if (has_hi) begin
      repl = hi_or_zero;
    end else begin
      repl = F32_ZERO;
    end
  end

  assign lt_lo = bd_en && !nonfin && has_lo && f32_lt(sample_i, cfg_i.min_bound);
  assign gt_hi = bd_en && !nonfin && has_hi && f32_lt(cfg_i.max_bound, sample_i);

  // upper bound wins when the bounds are crossed
  always_comb begin
    clamp_v = sample_i;
    if (lt_lo) begin
      clamp_v = cfg_i.min_bound;
    end
    if (gt_hi) begin
      clamp_v = cfg_i.max_bound;
    end
  end

  always_comb begin
    out_bits_o = sample_i;
    if (sanitize) begin
      if (nonfin && cfg_i.nonfin_chk) begin
        out_bits_o = repl;
      end else if (!nonfin) begin
        out_bits_o = clamp_v;
      end
    end
  end

  assign cls_o.is_nan = nonfin && (sample_i[22:0] != 23'd0);
  assign cls_o.is_inf = nonfin && (sample_i[22:0] == 23'd0);
  assign cls_o.is_fin = !nonfin;
  assign cls_o.below  = lt_lo;
  assign cls_o.above  = gt_hi;

endmodule

@@ src/fsg_dadd.sv @@
module fsg_dadd (
  input  logic [63:0] acc_i,
  input  logic [31:0] smp_i,
  output logic [63:0] sum_o
);

  function automatic logic [4:0] msb23(logic [22:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (x[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [5:0] lzc56(logic [55:0] x);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (x[i]) begin
        n = 6'(55 - i);
      end
    end
    return n;
  endfunction

  logic [10:0]  b_exp, ex, ey, d, r_exp;
  logic [51:0]  b_frac, fx, fy;
  logic [4:0]   p;
  logic [31:0]  sh;
  logic         sx, sy, swap, sub;
  logic [6:0]   d_cap;
  logic [111:0] tmp;
  logic [55:0]  al, xw, nrm;
  logic [56:0]  raw;
  logic [5:0]   lz;
  logic [11:0]  e_n, e_r;
  logic         up;
  logic [53:0]  m_r;

  // widen the float32 sample to float64
  assign p  = msb23(smp_i[22:0]);
  assign sh = {9'd0, smp_i[22:0]} << (5'd23 - p);

  always_comb begin
    if (smp_i[30:23] != 8'd0) begin
      b_exp  = {3'd0, smp_i[30:23]} + 11'd896;
      b_frac = {smp_i[22:0], 29'd0};
    end else if (smp_i[22:0] != 23'd0) begin
      b_exp  = 11'd874 + {6'd0, p};
      b_frac = {sh[22:0], 29'd0};
    end else begin
      b_exp  = 11'd0;
      b_frac = 52'd0;
    end
  end

  // order by magnitude
  assign swap = {b_exp, b_frac} > acc_i[62:0];
  assign sx = swap ? smp_i[31] : acc_i[63];
  assign ex = swap ? b_exp : acc_i[62:52];
  assign fx = swap ? b_frac : acc_i[51:0];
  assign sy = swap ? acc_i[63] : smp_i[31];
  assign ey = swap ? acc_i[62:52] : b_exp;
  assign fy = swap ? acc_i[51:0] : b_frac;

  assign sub   = sx ^ sy;
  assign d     = ex - ey;
  assign d_cap = (d > 11'd111) ? 7'd111 : d[6:0];
  assign tmp   = {(ey != 11'd0), fy, 59'd0} >> d_cap;
  assign al    = {tmp[111:57], |tmp[56:0]};
  assign xw    = {(ex != 11'd0), fx, 3'd0};
  assign raw   = sub ? ({1'b0, xw} - {1'b0, al}) : ({1'b0, xw} + {1'b0, al});

  assign lz = lzc56(raw[55:0]);

  always_comb begin
    if (raw[56]) begin
      nrm = {raw[56:2], raw[1] | raw[0]};
      e_n = {1'b0, ex} + 12'd1;
    end else begin
      nrm = raw[55:0] << lz;
      e_n = {1'b0, ex} - {6'd0, lz};
    end
  end

  // round to nearest, ties to even
  assign up    = nrm[2] && (nrm[1] || nrm[0] || nrm[3]);
  assign m_r   = {1'b0, nrm[55:3]} + {53'd0, up};
  assign e_r   = m_r[53] ? e_n + 12'd1 : e_n;
  assign r_exp = e_r[10:0];

  always_comb begin
    if (raw == 57'd0) begin
      sum_o = {(sub ? 1'b0 : sx), 63'd0};
    end else if (m_r[53]) begin
      sum_o = {sx, r_exp, m_r[52:1]};
    end else begin
      sum_o = {sx, r_exp, m_r[51:0]};
    end
  end

endmodule

@@ src/float_stream_guard_sanitizer_top.sv @@
// Channel | Direction | Handshake               | Payload
// in      | request   | in_valid_i / in_stall_o | in_data_i   (sample_bits, is_last)
// out     | result    | out_valid_o / out_stall_i| out_data_o (sample and statistics)
// cfg     | write     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One request per cycle sustained while the output does not stall; an accepted request passes
// through the input register and then the result register to out_valid_o. The float64 running
// sum closes a loop through one adder, which sets the clock period.
// Reset clears the statistics to their empty-buffer values and the registers to defaults.
// A stall on the output holds the result register; the input register then fills and stalls in.
module float_stream_guard_sanitizer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fsg_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fsg_pkg::out_item_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import fsg_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_data_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  logic      adv, take, step;

  count_t      nan_q, inf_q, fin_q, below_q, above_q;
  count_t      nan_d, inf_d, fin_d, below_d, above_d;
  logic [31:0] min_q, max_q, min_d, max_d;
  logic [63:0] sum_q, sum_d, sum_add;

  logic [31:0] s_bits, out_bits;
  cls_t        cls;
  logic        last, nf_en, bd_en, scope, fail_nf, fail_bd;
  logic [3:0]  flags;

  // Configuration: always ready; written only while idle, which the user must ensure and the block leaves unchecked.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE_SEL:        cfg_d.mode_sel        = cfg_data_i[1:0];
        REG_NONFIN_CHK:      cfg_d.nonfin_chk      = cfg_data_i[0];
        REG_BOUND_CHK:       cfg_d.bound_chk       = cfg_data_i[0];
        REG_BOUND_ENABLES:   cfg_d.bound_enables   = cfg_data_i[1:0];
        REG_MIN_BOUND:       cfg_d.min_bound       = cfg_data_i;
        REG_MAX_BOUND:       cfg_d.max_bound       = cfg_data_i;
        REG_FAIL_CRITERION:  cfg_d.fail_criterion  = cfg_data_i[1:0];
        REG_STRICT_IN_SCOPE: cfg_d.strict_in_scope = cfg_data_i[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  // Handshake: advance the input register whenever the result register is free or drains.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign take       = in_valid_i && !in_stall_o;
  assign step       = adv && s1_valid_q;
  assign s1_valid_d = take ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = adv ? s1_valid_q : out_valid_q;

  assign s_bits = s1_data_q.sample_bits;
  assign last   = s1_data_q.is_last;

  fsg_sample u_sample (
    .sample_i   (s_bits),
    .cfg_i      (cfg_q),
    .out_bits_o (out_bits),
    .cls_o      (cls)
  );

  fsg_dadd u_dadd (
    .acc_i (sum_q),
    .smp_i (s_bits),
    .sum_o (sum_add)
  );

  // Running statistics including the current sample.
  always_comb begin
    nan_d   = cnt_bump(nan_q, cls.is_nan);
    inf_d   = cnt_bump(inf_q, cls.is_inf);
    fin_d   = cnt_bump(fin_q, cls.is_fin);
    below_d = cnt_bump(below_q, cls.below);
    above_d = cnt_bump(above_q, cls.above);
    min_d   = (cls.is_fin && f32_lt(s_bits, min_q)) ? s_bits : min_q;
    max_d   = (cls.is_fin && f32_lt(max_q, s_bits)) ? s_bits : max_q;
    sum_d   = cls.is_fin ? sum_add : sum_q;
  end

  // End-of-buffer verdict.
  assign nf_en   = cfg_q.nonfin_chk;
  assign bd_en   = cfg_q.bound_chk && (cfg_q.bound_enables != 2'd0);
  assign scope   = (cfg_q.mode_sel == GUARD_STRICT) && cfg_q.strict_in_scope;
  assign fail_nf = (cfg_q.fail_criterion == FAIL_NONFINITE) ||
                   (cfg_q.fail_criterion == FAIL_BOTH);
  assign fail_bd = (cfg_q.fail_criterion == FAIL_BOUNDS) ||
                   (cfg_q.fail_criterion == FAIL_BOTH);

  always_comb begin
    flags = 4'd0;
    if (last && nf_en && ((nan_d != '0) || (inf_d != '0))) begin
      flags[0] = 1'b1;
      flags[1] = scope && fail_nf;
    end
    if (last && bd_en && ((below_d != '0) || (above_d != '0))) begin
      flags[2] = 1'b1;
      flags[3] = scope && fail_bd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{mode_sel: GUARD_OFF, nonfin_chk: 1'b1, bound_chk: 1'b1,
                       bound_enables: 2'd0, min_bound: 32'd0, max_bound: 32'd0,
                       fail_criterion: FAIL_BOTH, strict_in_scope: 1'b1};
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      nan_q       <= '0;
      inf_q       <= '0;
      fin_q       <= '0;
      below_q     <= '0;
      above_q     <= '0;
      min_q       <= F32_POS_INF;
      max_q       <= F32_NEG_INF;
      sum_q       <= F64_ZERO;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (step) begin
        // drop the statistics after the last sample of a buffer
        nan_q   <= last ? '0 : nan_d;
        inf_q   <= last ? '0 : inf_d;
        fin_q   <= last ? '0 : fin_d;
        below_q <= last ? '0 : below_d;
        above_q <= last ? '0 : above_d;
        min_q   <= last ? F32_POS_INF : min_d;
        max_q   <= last ? F32_NEG_INF : max_d;
        sum_q   <= last ? F64_ZERO : sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_data_q <= in_data_i;
    end
    if (step) begin
      out_q.out_bits        <= out_bits;
      out_q.end_mark        <= last;
      out_q.nan_total       <= cnt_show(nan_d);
      out_q.inf_total       <= cnt_show(inf_d);
      out_q.finite_total    <= cnt_show(fin_d);
      out_q.below_total     <= cnt_show(below_d);
      out_q.above_total     <= cnt_show(above_d);
      out_q.least_bits      <= min_d;
      out_q.greatest_bits   <= max_d;
      out_q.sum_bits        <= sum_d;
      out_q.violation_flags <= flags;
      out_q.strict_failed   <= flags[1] | flags[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_flags_only_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.end_mark |-> out_data_o.violation_flags == 4'd0)
    else $error("violation flags on a non-last result");

  a_strict_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.strict_failed ==
      (out_data_o.violation_flags[1] | out_data_o.violation_flags[3]))
    else $error("strict failure disagrees with critical flags");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last |=> (nan_q == '0) && (fin_q == '0) && (sum_q == F64_ZERO))
    else $error("statistics not cleared after last sample");

  a_stall_needs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room to advance");

endmodule
